[hdl/shash_pkg.sv]
// Shared constants, types and helpers for the 32-bit string hash block.
`default_nettype none
package shash_pkg;

	localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2   = 32'h1b873593;
	localparam logic [31:0] HASH_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

	localparam logic [2:0] COUNT_FULL = 3'd4;

	localparam int FIFO_DEPTH_DEF = 4;

	// One scrambled key on its way from the front to the back.
	typedef struct packed {
		logic [31:0] key;
		logic [2:0]  count;
		logic        is_full;
		logic        last;
	} item_t;

	// Keeps the valid low-order bytes of a tail word.
	function automatic logic [31:0] tail_mask(input logic [2:0] count);
		logic [31:0] m;
		case (count)
			3'd0: m = 32'h00000000;
			3'd1: m = 32'h000000ff;
			3'd2: m = 32'h0000ffff;
			3'd3: m = 32'h00ffffff;
			default: m = 32'hffffffff;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/shash_front.sv]
// Front part: takes input beats, classifies them and scrambles the key word.
`default_nettype none
module shash_front
	import shash_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	input  wire logic        fifo_full,
	output logic             push,
	output item_t            push_item
);

	logic        adv;
	logic [2:0]  count_n;
	logic [31:0] masked;
	logic        v_s1, v_s2;
	item_t       meta_s1, item_s2;
	logic [31:0] rot_k1;

	// Non-last beats and counts above four are taken as a full word.
	assign count_n = (!last || !(byte_count inside {[3'd0:3'd4]})) ? COUNT_FULL : byte_count;
	assign masked  = data_word & tail_mask(count_n);

	assign adv      = !v_s2 || !fifo_full;
	assign in_stall = !adv;
	assign push     = v_s2 && !fifo_full;
	assign push_item = item_s2;
	// The first stage holds the key after the first multiply.
	assign rot_k1   = {meta_s1.key[16:0], meta_s1.key[31:17]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.key     <= 32'(masked * MIX_C1);
			meta_s1.count   <= count_n;
			meta_s1.is_full <= (count_n == COUNT_FULL);
			meta_s1.last    <= last;
			item_s2.key     <= 32'(rot_k1 * MIX_C2);
			item_s2.count   <= meta_s1.count;
			item_s2.is_full <= meta_s1.is_full;
			item_s2.last    <= meta_s1.last;
		end
	end

endmodule
`default_nettype wire

[hdl/shash_fifo.sv]
// Short register queue that decouples the front from the back.
`default_nettype none
module shash_fifo
	import shash_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      push_item,
	input  wire logic  pop,
	output item_t      head,
	output logic       not_empty,
	output logic       full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (do_pop && !do_push) cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

[hdl/shash_back.sv]
// Back part: folds keys into the running hash and runs the finalizer.
`default_nettype none
module shash_back
	import shash_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] seed,
	input  item_t            head,
	input  wire logic        not_empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_value
);

	logic        adv;
	logic [31:0] acc_q, len_q;
	logic        mid_q;
	logic [31:0] h_base, len_base, hx, rot, h_full, h_new, len_new, fin_x;
	logic        v_s1, v_s2, v_s3, out_valid_q;
	logic [31:0] fin_s1, fin_s2, fin_s3, x13, out_hash_q;

	assign adv = !(out_valid_q && out_stall);
	assign pop = not_empty && adv;

	assign h_base   = mid_q ? acc_q : seed;
	assign len_base = mid_q ? len_q : '0;
	assign hx       = h_base ^ head.key;
	assign rot      = {hx[18:0], hx[31:19]};
	assign h_full   = 32'({rot[29:0], 2'b00} + rot + HASH_ADD);
	assign h_new    = head.is_full ? h_full : hx;
	assign len_new  = 32'(len_base + 32'(head.count));
	assign fin_x    = h_new ^ len_new;
	assign x13      = fin_s2 ^ (fin_s2 >> 13);

	assign out_valid  = out_valid_q;
	assign hash_value = out_hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			len_q       <= '0;
			mid_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (pop) begin
				acc_q <= h_new;
				len_q <= len_new;
				mid_q <= !head.last;
			end
			v_s1        <= pop && head.last;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s1     <= fin_x ^ (fin_x >> 16);
			fin_s2     <= 32'(fin_s1 * FIN_M1);
			fin_s3     <= 32'(x13 * FIN_M2);
			out_hash_q <= fin_s3 ^ (fin_s3 >> 16);
		end
	end

endmodule
`default_nettype wire

[hdl/string_hash_32_top.sv]
// Top level of the 32-bit string hash block.
// This block computes the 32-bit murmur-style hash of a byte string that
// arrives as little-endian 32-bit words, one word per input beat, with a
// valid-byte count and a last flag. Every non-last beat counts as four bytes;
// the last beat carries zero to four bytes, and a last beat with zero bytes
// closes the message (on its own it hashes the empty string). One output beat
// with the finished hash follows every last beat. The back reads the seed as
// it folds the first key of a message, so a new seed applies to each message
// whose first key it folds later. While the result side does not stall, the
// block takes one beat per clock cycle: the front scrambles each word in a
// two-stage multiply pipeline, a four-entry queue buffers the scrambled keys,
// and the back folds one key per cycle into the running hash, which is the
// only serial loop in the design. After its last beat is accepted, a hash
// passes through the two front stages, the queue, the fold with the first
// finalizer step, two more finalizer stages and the output register. Each
// side stalls on its own; the input stalls only once the queue has filled.
`default_nettype none
module string_hash_32_top
	import shash_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	// Result beats.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_value,
	// Seed register write.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] seed_value
);

	logic        seed_q;
	logic [31:0] seed_reg_q;
	logic        push, pop, fifo_full, fifo_not_empty;
	item_t       push_item, head;

	// The seed register can always take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg_q <= '0;
			seed_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			seed_reg_q <= seed_value;
			seed_q     <= 1'b1;
		end
	end

	// The front classifies each beat and scrambles its word.
	shash_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_item  (push_item)
	);

	shash_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (fifo_not_empty),
		.full      (fifo_full)
	);

	// The back holds the running hash and the byte length of the open message.
	// Until the first write the seed reads as zero, which is the reset value.
	shash_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q ? seed_reg_q : 32'h0),
		.head       (head),
		.not_empty  (fifo_not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule
`default_nettype wire

[hdl/shash_checker.sv]
// Port-level checker for the string hash block and its bind.
`default_nettype none
module shash_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] hash_value
);

	// A result beat held back by the receiver keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("stalled result beat changed");

	// Reset leaves no result beat pending and the input side not stalled.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid && !in_stall)
		else $error("beat pending during reset");

	// The queue can only have filled while the output was held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without output backpressure");

endmodule

bind string_hash_32_top shash_checker u_shash_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the 32-bit string hash block.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shash_pkg::*;

	// The run stops with a failure if it has not ended after this many cycles.
	localparam int LIMIT_CYCLES = 400000;
	// Cycles allowed after the last expected hash before the block counts as idle.
	localparam int SETTLE_CYCLES = 12;
	// Least number of beats in each random phase. Every phase starts with a new seed.
	localparam int PHASE_BEATS = 258;
	localparam int PHASE_COUNT = 6;
	// Length of the long hold-off on the result side.
	localparam int HOLD_CYCLES = 120;

	// Receiver behavior for one stretch of cycles.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC,
		RX_HOLD
	} rx_mode_t;

	// The scoreboard keeps its own copy of the hash state and of the seed.
	// Every accepted input beat is folded in as soon as it is accepted. A last beat
	// finishes the hash and queues it. Result beats are matched in order.
	class hash_board_t;
		logic [31:0] seed_reg;
		logic [31:0] accum;
		logic [31:0] byte_total;
		bit          open_msg;
		logic [31:0] expected_hashes[$];
		int          errors;

		function new();
			seed_reg = '0;
			accum = '0;
			byte_total = '0;
			open_msg = 1'b0;
			errors = 0;
		endfunction

		function logic [31:0] rotl(input logic [31:0] v, input int s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function logic [31:0] scramble_key(input logic [31:0] k);
			logic [31:0] t;
			t = k * MIX_C1;
			t = rotl(t, 15);
			t = t * MIX_C2;
			return t;
		endfunction

		function logic [31:0] avalanche(input logic [31:0] h);
			logic [31:0] t;
			t = h ^ (h >> 16);
			t = t * FIN_M1;
			t = t ^ (t >> 13);
			t = t * FIN_M2;
			t = t ^ (t >> 16);
			return t;
		endfunction

		function void set_seed(input logic [31:0] v);
			seed_reg = v;
		endfunction

		function void note_beat(input logic [31:0] w, input logic [2:0] c, input logic l);
			logic [31:0] h;
			logic [2:0]  n;
			logic [31:0] mask;
			// The first beat of a message loads the seed and clears the length.
			if (!open_msg) begin
				accum = seed_reg;
				byte_total = '0;
				open_msg = 1'b1;
			end
			// Beats that are not last, and counts above four, carry a full word.
			n = (!l || c > COUNT_FULL) ? COUNT_FULL : c;
			h = accum;
			if (n == COUNT_FULL) begin
				h = h ^ scramble_key(w);
				h = rotl(h, 13);
				h = h * 32'd5 + HASH_ADD;
			end else if (n != 3'd0) begin
				// A tail of one to three bytes is scrambled and xored in, with no rotate step.
				mask = (32'd1 << (8 * int'(n))) - 32'd1;
				h = h ^ scramble_key(w & mask);
			end
			byte_total = byte_total + 32'(n);
			accum = h;
			if (l) begin
				expected_hashes.insert(expected_hashes.size(), avalanche(h ^ byte_total));
				open_msg = 1'b0;
			end
		endfunction

		function void log_error(input string what, input logic [31:0] want,
				input logic [31:0] got);
			errors++;
			if (errors <= 10) begin
				$display("%s: expected %h, got %h", what, want, got);
			end
		endfunction

		function void check_hash(input logic [31:0] got);
			logic [31:0] want;
			if (expected_hashes.size() == 0) begin
				log_error("hash beat with no message closed", 'x, got);
				return;
			end
			want = expected_hashes.pop_front();
			if (got !== want) begin
				log_error("hash mismatch", want, got);
			end
		endfunction

		function int pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] hash_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] seed_value;

	hash_board_t board = new();

	// Sender burst state. A burst ends with an optional gap before the next beat.
	int burst_left = 0;
	int beats_sent = 0;
	int cycle_count = 0;

	string_hash_32_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value)
	);

	always begin
		clk = 1'b0;
		#5ns;
		clk = 1'b1;
		#5ns;
	end

	// A run that does not end in time is a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[string_hash_32_top] ERROR");
			$finish;
		end
	end

	// Result monitor. It reads the values from before the edge, so the order of
	// processes within the time step does not matter.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_hash(hash_value);
		end
	end

	// The result side stalls on a pattern of its own, one stretch at a time.
	// Every twelfth stretch is a long hold-off. The sender keeps offering beats
	// during it, so the queue fills and the input side must stall.
	initial begin
		rx_mode_t mode;
		int       stretch;
		int       len;
		int       k;
		out_stall <= 1'b0;
		stretch = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (stretch % 12 == 2) begin
				mode = RX_HOLD;
				len = HOLD_CYCLES;
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				len = $urandom_range(10, 150);
			end
			stretch++;
			for (k = 0; k < len; k++) begin
				@(posedge clk);
				case (mode)
					RX_FREE: out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
					RX_PERIODIC: out_stall <= (k % 3 == 0);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	// Offers one input beat and waits until the block takes it. Gaps between
	// bursts drop valid. The payload is held while stalled.
	task automatic send_beat(input logic [31:0] w, input logic [2:0] c, input logic l);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_word <= w;
		byte_count <= c;
		last <= l;
		do begin
			@(posedge clk);
		end while (in_stall);
		board.note_beat(w, c, l);
		beats_sent++;
	endtask

	// Drops valid and waits until every hash has arrived and the pipeline is empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the seed register. The caller makes sure that the block is idle.
	task automatic write_seed(input logic [31:0] v);
		cfg_valid <= 1'b1;
		seed_value <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_seed(v);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			default: return $urandom();
		endcase
	endfunction

	// Sends one message of the given number of beats. Most beats that are not
	// last carry a count of four. The rest carry noise counts, which the block
	// must treat as four. The last beat usually carries zero to four bytes.
	task automatic send_message(input int words);
		int          i;
		int          r;
		logic [2:0]  c;
		for (i = 0; i < words; i++) begin
			if (i == words - 1) begin
				r = $urandom_range(0, 19);
				c = (r < 16) ? 3'(r % 5) : 3'($urandom_range(5, 7));
				send_beat(pick_word(), c, 1'b1);
			end else begin
				c = ($urandom_range(0, 9) < 3) ? 3'($urandom_range(0, 7)) : COUNT_FULL;
				send_beat(pick_word(), c, 1'b0);
			end
		end
	endtask

	initial begin
		logic [31:0] phase_seeds[PHASE_COUNT];
		int          p;
		int          phase_start;
		int          r;
		int          words;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_word <= '0;
		byte_count <= '0;
		last <= 1'b0;
		cfg_valid <= 1'b0;
		seed_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the reset seed of zero.
		// The empty string is a last beat with no bytes, and its data must be ignored.
		send_beat($urandom(), 3'd0, 1'b1);
		// Single-beat messages with tails of one, two and three bytes, and a full word.
		send_beat(32'hffffffff, 3'd1, 1'b1);
		send_beat(32'hffffffff, 3'd2, 1'b1);
		send_beat(32'h00000000, 3'd3, 1'b1);
		send_beat($urandom(), COUNT_FULL, 1'b1);
		// Counts above four on a last beat count as a full word.
		send_beat($urandom(), 3'd5, 1'b1);
		send_beat($urandom(), 3'd6, 1'b1);
		send_beat($urandom(), 3'd7, 1'b1);
		// Beats that are not last always carry four bytes. The tail ignores
		// the bytes above its count.
		send_beat(32'hffffffff, 3'd0, 1'b0);
		send_beat(32'h00000000, 3'd7, 1'b0);
		send_beat(32'hffffffff, 3'd3, 1'b1);

		// Seed at its upper extreme.
		wait_idle();
		write_seed(32'hffffffff);
		send_beat($urandom(), 3'd2, 1'b1);
		send_beat(32'h00000000, 3'd0, 1'b1);

		// A seed written while a message is open applies to the next message only.
		send_beat($urandom(), COUNT_FULL, 1'b0);
		wait_idle();
		write_seed(32'h9e3779b9);
		send_beat($urandom(), 3'd1, 1'b1);
		send_beat($urandom(), COUNT_FULL, 1'b1);

		// Random phases. Each phase starts idle with its own seed. Most messages
		// are short, and a few are long.
		phase_seeds[0] = 32'h00000000;
		phase_seeds[1] = 32'hffffffff;
		phase_seeds[2] = $urandom();
		phase_seeds[3] = 32'h00000001;
		phase_seeds[4] = $urandom();
		phase_seeds[5] = 32'h80000000;
		for (p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			write_seed(phase_seeds[p]);
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				r = $urandom_range(0, 19);
				if (r < 14) begin
					words = $urandom_range(1, 4);
				end else if (r < 19) begin
					words = $urandom_range(5, 16);
				end else begin
					words = $urandom_range(17, 48);
				end
				send_message(words);
			end
		end

		wait_idle();
		if (board.pending() != 0) begin
			$display("%0d hashes never arrived", board.pending());
		end
		if (board.errors == 0 && board.pending() == 0) begin
			$display("[string_hash_32_top] OK");
		end else begin
			$display("[string_hash_32_top] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
hdl/shash_pkg.sv
hdl/shash_front.sv
hdl/shash_fifo.sv
hdl/shash_back.sv
hdl/string_hash_32_top.sv
hdl/shash_checker.sv
test/tb_top.sv
